### sv/bpa_pkg.sv
`default_nettype none
package bpa_pkg;

  localparam int unsigned PAGE_COUNT_DEF = 16384;
  localparam int unsigned PAGE_SHIFT_DEF = 12;
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned CNT_W = 15;
  localparam int unsigned RADDR_W = 26;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_REGION = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_ZERO = 3'd1;
  localparam logic [2:0] ST_NOSPACE = 3'd2;
  localparam logic [2:0] ST_MISALIGN = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;
  localparam logic [2:0] ST_DOUBLE = 3'd5;

  typedef struct packed {
    logic [1:0] operation;
    logic [ADDR_W-1:0] address;
    logic [CNT_W-1:0] page_count;
    logic [ADDR_W-1:0] region_length;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [RADDR_W-1:0] result_address;
    logic [CNT_W-1:0] pages_done;
    logic page_free;
    logic [CNT_W-1:0] free_count;
    logic [CNT_W-1:0] used_count;
    logic [CNT_W-1:0] total_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN,
    S_MARK_RD,
    S_MARK,
    S_WALK_RD,
    S_WALK,
    S_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic clear_step;
    logic load;
    logic decode;
    logic scan_rd;
    logic scan;
    logic mark_rd;
    logic mark;
    logic walk_rd;
    logic walk;
    logic finish;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_last;
    logic imm_done;   // result settled at decode
    logic is_alloc;
    logic scan_found;
    logic scan_end;
    logic mark_last;
    logic walk_last;
  } sts_t;

endpackage
`default_nettype wire

### sv/bitmap_page_allocator_core.sv
`default_nettype none
// Immediate results (zero count, no space by count, misaligned, query,
// empty region) settle at decode; otherwise the controller scans, marks or
// walks the map page by page, over the whole map for a failing allocation.
// Throughput: one beat at a time; busy stays high until the result strobe.
// Reset: synchronous; a clearing pass over the map words then sets every
// page used, busy is high meanwhile. The receiver cannot stall results.
module bitmap_page_allocator_core #(
  parameter int unsigned PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF,
  parameter int unsigned PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire bpa_pkg::req_t request,
  output logic strobe,
  output bpa_pkg::rsp_t result
);

  bpa_pkg::cmd_t cmd;
  bpa_pkg::sts_t sts;

  // Sequence each beat: decode, then scan, mark or walk the map.
  bpa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  // Hold the page map, counters and the result register.
  bpa_dpath #(.PAGE_COUNT(PAGE_COUNT), .PAGE_SHIFT(PAGE_SHIFT)) u_dpath (
    .clk(clk), .rst(rst), .req(request), .cmd(cmd), .sts(sts),
    .result(result), .strobe(strobe)
  );

endmodule
`default_nettype wire

### sv/bpa_ctrl.sv
`default_nettype none
module bpa_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire bpa_pkg::sts_t sts,
  output bpa_pkg::cmd_t cmd
);

  bpa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= bpa_pkg::S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    case (state)
      bpa_pkg::S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_next = bpa_pkg::S_IDLE;
      end
      bpa_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          state_next = bpa_pkg::S_DECODE;
        end
      end
      bpa_pkg::S_DECODE: begin
        cmd.decode = 1'b1;
        if (sts.imm_done) state_next = bpa_pkg::S_DONE;
        else if (sts.is_alloc) state_next = bpa_pkg::S_SCAN_RD;
        else state_next = bpa_pkg::S_WALK_RD;
      end
      bpa_pkg::S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next = bpa_pkg::S_SCAN;
      end
      bpa_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_found) state_next = bpa_pkg::S_MARK_RD;
        else if (sts.scan_end) state_next = bpa_pkg::S_DONE;
        else state_next = bpa_pkg::S_SCAN_RD;
      end
      bpa_pkg::S_MARK_RD: begin
        cmd.mark_rd = 1'b1;
        state_next = bpa_pkg::S_MARK;
      end
      bpa_pkg::S_MARK: begin
        cmd.mark = 1'b1;
        if (sts.mark_last) state_next = bpa_pkg::S_DONE;
        else state_next = bpa_pkg::S_MARK_RD;
      end
      bpa_pkg::S_WALK_RD: begin
        cmd.walk_rd = 1'b1;
        state_next = bpa_pkg::S_WALK;
      end
      bpa_pkg::S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_last) state_next = bpa_pkg::S_DONE;
        else state_next = bpa_pkg::S_WALK_RD;
      end
      bpa_pkg::S_DONE: begin
        cmd.finish = 1'b1;
        state_next = bpa_pkg::S_IDLE;
      end
      default: state_next = bpa_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### sv/bpa_dpath.sv
`default_nettype none
module bpa_dpath #(
  parameter int unsigned PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF,
  parameter int unsigned PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire bpa_pkg::req_t req,
  input  wire bpa_pkg::cmd_t cmd,
  output bpa_pkg::sts_t sts,
  output bpa_pkg::rsp_t result,
  output logic strobe
);

  localparam int unsigned WORDS = (PAGE_COUNT + 7) / 8;
  localparam int unsigned WA_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned PG_W = $clog2(PAGE_COUNT) + 1;  // holds PAGE_COUNT itself
  localparam int unsigned AW = bpa_pkg::ADDR_W + 2;
  localparam int unsigned CW = bpa_pkg::CNT_W;
  localparam logic [AW-1:0] MEM_BYTES = AW'(PAGE_COUNT) << PAGE_SHIFT;
  localparam logic [AW-1:0] PMASK = (AW'(1) << PAGE_SHIFT) - AW'(1);
  localparam logic [PG_W-1:0] PAGES = PG_W'(PAGE_COUNT);
  localparam logic [PG_W-1:0] LAST_PAGE = PG_W'(PAGE_COUNT - 1);
  localparam logic [WA_W-1:0] LAST_WORD = WA_W'(WORDS - 1);

  logic [7:0] map [WORDS];
  logic [7:0] rd_word;
  logic [WA_W-1:0] rd_addr;
  logic wr_en;
  logic [WA_W-1:0] wr_addr;
  logic [7:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) map[wr_addr] <= wr_data;
    rd_word <= map[rd_addr];
  end

  bpa_pkg::req_t r;
  logic [WA_W-1:0] clr_idx;
  logic [PG_W-1:0] page, last, run, start_pg;
  logic [CW-1:0] need, done, free_c, used_c, total_c;
  logic [2:0] status;
  logic pfree, found, pfree_q;
  logic [AW-1:0] addr_x, base, top;

  assign addr_x = AW'(r.address);
  assign base = (addr_x + PMASK) & ~PMASK;
  assign top = (addr_x + AW'(r.region_length)) & ~PMASK;

  logic [2:0] bit_sel;
  assign bit_sel = page[2:0];
  logic cur_used;
  assign cur_used = rd_word[bit_sel];
  logic [WA_W-1:0] page_word;
  assign page_word = WA_W'(page >> 3);

  // Decode fetches the word of the queried page so it is ready at finish.
  always_comb begin
    rd_addr = page_word;
    if (cmd.decode) rd_addr = WA_W'(addr_x >> (PAGE_SHIFT + 3));
    wr_en = 1'b0;
    wr_addr = page_word;
    wr_data = rd_word;
    if (cmd.clear_step) begin
      wr_en = 1'b1;
      wr_addr = clr_idx;
      wr_data = 8'hFF;
    end else if (cmd.mark) begin
      wr_en = 1'b1;
      wr_data[bit_sel] = 1'b1;
    end else if (cmd.walk && cur_used && !(r.operation == bpa_pkg::OP_FREE &&
                 page >= PAGES)) begin
      wr_en = 1'b1;
      wr_data[bit_sel] = 1'b0;
    end
  end

  always_comb begin
    sts = '0;
    sts.clear_last = (clr_idx == LAST_WORD);
    sts.is_alloc = (r.operation == bpa_pkg::OP_ALLOC);
    sts.imm_done = 1'b0;
    case (r.operation)
      bpa_pkg::OP_ALLOC: sts.imm_done = (r.page_count == '0) || (free_c < r.page_count);
      bpa_pkg::OP_FREE: sts.imm_done = (r.page_count == '0) || ((addr_x & PMASK) != '0);
      bpa_pkg::OP_QUERY: sts.imm_done = 1'b1;
      bpa_pkg::OP_REGION: sts.imm_done = !(base < MEM_BYTES) ||
          !(((top > MEM_BYTES) ? MEM_BYTES : top) > base);
      default: sts.imm_done = 1'b1;
    endcase
    sts.scan_found = !cur_used && ((run + 1'b1) == PG_W'(r.page_count));
    sts.scan_end = (page == LAST_PAGE);
    sts.mark_last = (page == last);
    if (r.operation == bpa_pkg::OP_FREE)
      sts.walk_last = (page >= PAGES) || (need == CW'(1));
    else
      sts.walk_last = (page == last);
  end

  function automatic logic [CW-1:0] inc_sat(input logic [CW-1:0] c);
    return (c < CW'(PAGE_COUNT)) ? c + 1'b1 : c;
  endfunction
  function automatic logic [CW-1:0] dec_sat(input logic [CW-1:0] c);
    return (c != '0) ? c - 1'b1 : c;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      clr_idx <= '0;
      free_c <= '0;
      used_c <= '0;
      total_c <= '0;
    end else begin
      strobe <= cmd.finish;
      if (cmd.clear_step) clr_idx <= clr_idx + 1'b1;
      if (cmd.load) begin
        r <= req;
        status <= bpa_pkg::ST_OK;
        done <= '0;
        pfree <= 1'b0;
        found <= 1'b0;
      end
      if (cmd.decode) begin
        run <= '0;
        case (r.operation)
          bpa_pkg::OP_ALLOC: begin
            page <= '0;
            if (r.page_count == '0) status <= bpa_pkg::ST_ZERO;
            else status <= bpa_pkg::ST_NOSPACE;
          end
          bpa_pkg::OP_FREE: begin
            page <= (addr_x >= MEM_BYTES) ? PAGES : PG_W'(addr_x >> PAGE_SHIFT);
            if (r.page_count != '0 && (addr_x & PMASK) != '0)
              status <= bpa_pkg::ST_MISALIGN;
            need <= r.page_count;
          end
          bpa_pkg::OP_QUERY: begin
            if (addr_x < MEM_BYTES) begin
              page <= PG_W'(addr_x >> PAGE_SHIFT);
              pfree <= 1'b1;  // refined at finish from the read word
            end
          end
          bpa_pkg::OP_REGION: begin
            page <= PG_W'(base >> PAGE_SHIFT);
            last <= PG_W'((((top > MEM_BYTES) ? MEM_BYTES : top) >> PAGE_SHIFT) - 1'b1);
          end
          default: ;
        endcase
      end
      if (cmd.scan) begin
        if (cur_used) run <= '0;
        else begin
          if (run == '0) start_pg <= page;
          run <= run + 1'b1;
        end
        if (sts.scan_found) begin
          found <= 1'b1;
          status <= bpa_pkg::ST_OK;
          page <= (run == '0) ? page : start_pg;
          last <= page;
          done <= r.page_count;
        end else begin
          page <= page + 1'b1;
        end
      end
      if (cmd.mark) begin
        page <= page + 1'b1;
        free_c <= dec_sat(free_c);
        used_c <= inc_sat(used_c);
      end
      if (cmd.walk) begin
        page <= page + 1'b1;
        need <= need - 1'b1;
        if (r.operation == bpa_pkg::OP_FREE) begin
          if (page >= PAGES) begin
            if (status == bpa_pkg::ST_OK) status <= bpa_pkg::ST_RANGE;
          end else if (!cur_used) begin
            if (status == bpa_pkg::ST_OK) status <= bpa_pkg::ST_DOUBLE;
          end else begin
            free_c <= inc_sat(free_c);
            used_c <= dec_sat(used_c);
            done <= done + 1'b1;
          end
        end else if (cur_used) begin
          free_c <= inc_sat(free_c);
          total_c <= inc_sat(total_c);
          done <= done + 1'b1;
        end
      end
    end
  end

  // The start of the found run stays in start_pg through marking.
  always_comb begin
    result.status = status;
    result.result_address = '0;
    if (r.operation == bpa_pkg::OP_ALLOC && found)
      result.result_address = bpa_pkg::RADDR_W'(AW'(start_pg) << PAGE_SHIFT);
    result.pages_done = done;
    result.page_free = pfree_q;
    result.free_count = free_c;
    result.used_count = used_c;
    result.total_count = total_c;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) pfree_q <= 1'b0;
    else if (cmd.finish) pfree_q <= pfree & !cur_used;
  end

endmodule
`default_nettype wire
